[rtl/core/plte_pkg.sv]
// shared types and constants for the piecewise-linear table evaluator
package plte_pkg;

    localparam int MAX_SEGMENTS_DEF = 16;
    localparam int QUEUE_DEPTH_DEF  = 2;

    localparam int DATA_W      = 32;
    localparam int IDX_W       = 4;
    localparam int SIU_W       = 5;
    localparam int FRAC_W      = 16;
    localparam int CFG_INDEX_W = 1;

    // command codes of an input item
    localparam logic CMD_EVALUATE = 1'b0;
    localparam logic CMD_WRITE    = 1'b1;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_MIN_X           = 1'b0,
        REG_SEGMENTS_IN_USE = 1'b1
    } cfg_reg_t;

    typedef enum logic [1:0] {
        STATUS_OK      = 2'd0,
        STATUS_BELOW   = 2'd1,
        STATUS_ABOVE   = 2'd2,
        STATUS_WRITTEN = 2'd3
    } status_t;

    // class of a queued item, decided by the front end
    typedef enum logic [1:0] {
        KIND_EVAL  = 2'd0,
        KIND_BELOW = 2'd1,
        KIND_WRITE = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_MUL,
        S_ADD,
        S_SAT,
        S_HOLD
    } back_state_t;

    typedef struct packed {
        logic                     command;
        logic signed [DATA_W-1:0] x_value;
        logic [IDX_W-1:0]         segment_index;
        logic signed [DATA_W-1:0] segment_upper_x;
        logic signed [DATA_W-1:0] segment_slope;
        logic signed [DATA_W-1:0] segment_intercept;
    } cmd_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] result_value;
        status_t                  status;
    } res_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] upper_x;
        logic signed [DATA_W-1:0] slope;
        logic signed [DATA_W-1:0] intercept;
    } seg_t;

    typedef struct packed {
        kind_t kind;
        cmd_t  cmd;
    } q_entry_t;

    // queue flags seen by both ends
    typedef struct packed {
        logic full;
        logic empty;
    } q_flags_t;

endpackage

[rtl/core/plte_cmd_if.sv]
// input item channel: valid, ready and command payload
interface plte_cmd_if
    import plte_pkg::*;
();
    logic valid;
    logic ready;
    cmd_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

[rtl/core/plte_res_if.sv]
// result item channel: valid, ready and result payload
interface plte_res_if
    import plte_pkg::*;
();
    logic valid;
    logic ready;
    res_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

[rtl/core/piecewise_linear_table_eval_core.sv]
// top level of the piecewise-linear table evaluator
// Evaluates slope*x+intercept (signed Q16.16, round half up, saturated) from a
// table of up to MAX_SEGMENTS segments held in a single-port-read RAM. Input
// transfers are classified by the front end and go through a QUEUE_DEPTH entry
// queue, so new items are taken while the back end works or a result waits.
// A segment write or a below-range evaluate is finished by the back end
// without a table search; other evaluates scan the table, reading one segment
// per cycle through the RAM read port until a segment's upper_x is at or above
// x or the clamped segments_in_use is used up, then multiply, add, saturate.
// The table needs no clearing after reset; configuration is to be written
// only while idle, which the block itself does not enforce.
module piecewise_linear_table_eval_core
    import plte_pkg::*;
#(
    parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF,
    parameter int QUEUE_DEPTH  = QUEUE_DEPTH_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [DATA_W-1:0]      cfg_data,
    plte_cmd_if.sink               cmd,
    plte_res_if.source             res
);
    logic signed [DATA_W-1:0] min_x_reg;
    logic [SIU_W-1:0]         siu_reg;
    logic                     push;
    q_entry_t                 push_entry;
    logic                     pop;
    q_entry_t                 head;
    q_flags_t                 flags;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_x_reg <= '0;
            siu_reg   <= SIU_W'(1);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_MIN_X:           min_x_reg <= cfg_data;
                REG_SEGMENTS_IN_USE: siu_reg   <= cfg_data[SIU_W-1:0];
                default:             ;
            endcase
        end
    end

    plte_front u_front (
        .cmd        (cmd),
        .min_x      (min_x_reg),
        .flags      (flags),
        .push       (push),
        .push_entry (push_entry)
    );

    plte_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .flags      (flags)
    );

    plte_back #(
        .MAX_SEGMENTS (MAX_SEGMENTS)
    ) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .segments_in_use (siu_reg),
        .flags           (flags),
        .head            (head),
        .pop             (pop),
        .res             (res)
    );
endmodule

[rtl/core/plte_ram.sv]
// generic simple dual-port ram with registered read
module plte_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 16
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic                                  re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

[rtl/core/plte_queue.sv]
// short fifo between the front end and the back end
module plte_queue
    import plte_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  q_entry_t push_entry,
    input  logic     pop,
    output q_entry_t head,
    output q_flags_t flags
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    q_entry_t        mem [DEPTH];
    logic [PW-1:0]   wr_ptr_reg;
    logic [PW-1:0]   rd_ptr_reg;
    logic [CW-1:0]   count_reg;

    // storage, no reset needed
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    assign head        = mem[rd_ptr_reg];
    assign flags.full  = (count_reg == CW'(DEPTH));
    assign flags.empty = (count_reg == '0);

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !flags.full)
        else $error("queue push while full");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !flags.empty)
        else $error("queue pop while empty");
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue count did not advance on push");
`endif
endmodule

[rtl/core/plte_front.sv]
// front end: takes input transfers and classifies them into the queue
module plte_front
    import plte_pkg::*;
(
    plte_cmd_if.sink                 cmd,
    input  logic signed [DATA_W-1:0] min_x,
    input  q_flags_t                 flags,
    output logic                     push,
    output q_entry_t                 push_entry
);
    // accept whenever the queue has room
    assign cmd.ready = !flags.full;
    assign push      = cmd.valid && !flags.full;

    // classify: segment write, below-range evaluate, or table search
    always_comb
    begin
        push_entry.cmd = cmd.payload;
        if (cmd.payload.command == CMD_WRITE)
        begin
            push_entry.kind = KIND_WRITE;
        end
        else if (cmd.payload.x_value < min_x)
        begin
            push_entry.kind = KIND_BELOW;
        end
        else
        begin
            push_entry.kind = KIND_EVAL;
        end
    end
endmodule

[rtl/core/plte_back.sv]
// back end: segment table, search sequencer, multiply-add and output register
module plte_back
    import plte_pkg::*;
#(
    parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic [SIU_W-1:0] segments_in_use,
    input  q_flags_t         flags,
    input  q_entry_t         head,
    output logic             pop,
    plte_res_if.source       res
);
    localparam int AW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
    localparam int CW = $clog2(MAX_SEGMENTS + 1);
    localparam int WIDE_W = 9;
    localparam logic signed [2*DATA_W-1:0] SAT_MAX  = 64'sh0000_0000_7FFF_FFFF;
    localparam logic signed [2*DATA_W-1:0] SAT_MIN  = 64'shFFFF_FFFF_8000_0000;
    localparam logic signed [2*DATA_W-1:0] ROUND_HALF = 64'sd1 <<< (FRAC_W - 1);

    back_state_t              state_reg, state_next;
    logic [CW-1:0]            cnt_reg, cnt_next;
    logic [CW-1:0]            cnt_inc;
    logic [CW-1:0]            lim;
    logic [WIDE_W-1:0]        siu_wide;
    logic [WIDE_W-1:0]        idx_wide;
    logic signed [DATA_W-1:0] x_reg, x_next;
    logic signed [DATA_W-1:0] slope_reg, slope_next;
    logic signed [DATA_W-1:0] icpt_reg, icpt_next;
    logic signed [2*DATA_W-1:0] prod_reg;
    logic signed [2*DATA_W-1:0] sum_reg;
    logic signed [2*DATA_W-1:0] icpt_scaled;
    logic signed [2*DATA_W-1:0] shifted;
    logic signed [DATA_W-1:0] sat_value;
    seg_t                     seg_rd;
    seg_t                     seg_wr;
    logic                     ram_we, ram_re;
    logic [AW-1:0]            ram_raddr, ram_waddr;
    logic [$bits(seg_t)-1:0]  ram_rdata;
    logic                     fin_valid;
    res_t                     fin_data;
    res_t                     hold_reg;
    logic                     out_free, out_load;
    res_t                     out_load_data;
    logic                     out_valid_reg;
    res_t                     out_data_reg;

    // search limit, clamped to the table depth
    assign siu_wide = {{(WIDE_W - SIU_W){1'b0}}, segments_in_use};
    assign lim = (siu_wide > WIDE_W'(MAX_SEGMENTS)) ? CW'(MAX_SEGMENTS) : siu_wide[CW-1:0];
    assign cnt_inc = cnt_reg + 1'b1;

    // segment write address and drop of out-of-table indexes
    assign idx_wide  = {{(WIDE_W - IDX_W){1'b0}}, head.cmd.segment_index};
    assign ram_waddr = idx_wide[AW-1:0];
    assign seg_wr.upper_x   = head.cmd.segment_upper_x;
    assign seg_wr.slope     = head.cmd.segment_slope;
    assign seg_wr.intercept = head.cmd.segment_intercept;
    assign seg_rd = seg_t'(ram_rdata);

    plte_ram #(
        .WIDTH ($bits(seg_t)),
        .DEPTH (MAX_SEGMENTS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (seg_wr),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // rounding and saturation of the q32.32 sum
    assign icpt_scaled = {{(DATA_W - FRAC_W){icpt_reg[DATA_W-1]}}, icpt_reg, {FRAC_W{1'b0}}};
    assign shifted     = sum_reg >>> FRAC_W;
    always_comb
    begin
        if (shifted > SAT_MAX)
        begin
            sat_value = SAT_MAX[DATA_W-1:0];
        end
        else if (shifted < SAT_MIN)
        begin
            sat_value = SAT_MIN[DATA_W-1:0];
        end
        else
        begin
            sat_value = shifted[DATA_W-1:0];
        end
    end

    assign out_free = !out_valid_reg || res.ready;

    // sequencer state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        x_reg     <= x_next;
        slope_reg <= slope_next;
        icpt_reg  <= icpt_next;
        if (state_reg == S_MUL)
        begin
            prod_reg <= x_reg * slope_reg;
        end
        if (state_reg == S_ADD)
        begin
            sum_reg <= prod_reg + icpt_scaled + ROUND_HALF;
        end
        if (fin_valid)
        begin
            hold_reg <= fin_data;
        end
    end

    // next state, table access and finished results
    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        x_next       = x_reg;
        slope_next   = slope_reg;
        icpt_next    = icpt_reg;
        pop          = 1'b0;
        ram_we       = 1'b0;
        ram_re       = 1'b0;
        ram_raddr    = '0;
        fin_valid    = 1'b0;
        fin_data.result_value = '0;
        fin_data.status       = STATUS_OK;
        unique case (state_reg)
            S_IDLE:
            begin
                if (!flags.empty)
                begin
                    pop    = 1'b1;
                    x_next = head.cmd.x_value;
                    unique case (head.kind)
                        KIND_WRITE:
                        begin
                            ram_we          = (idx_wide < WIDE_W'(MAX_SEGMENTS));
                            fin_valid       = 1'b1;
                            fin_data.status = STATUS_WRITTEN;
                        end
                        KIND_BELOW:
                        begin
                            fin_valid       = 1'b1;
                            fin_data.status = STATUS_BELOW;
                        end
                        default:
                        begin
                            if (lim == '0)
                            begin
                                fin_valid       = 1'b1;
                                fin_data.status = STATUS_ABOVE;
                            end
                            else
                            begin
                                ram_re     = 1'b1;
                                cnt_next   = '0;
                                state_next = S_CHECK;
                            end
                        end
                    endcase
                end
            end
            S_CHECK:
            begin
                // entry cnt_reg is on the read port; prefetch the next one
                if (x_reg <= seg_rd.upper_x)
                begin
                    slope_next = seg_rd.slope;
                    icpt_next  = seg_rd.intercept;
                    state_next = S_MUL;
                end
                else if (cnt_inc < lim)
                begin
                    ram_re    = 1'b1;
                    ram_raddr = cnt_inc[AW-1:0];
                    cnt_next  = cnt_inc;
                end
                else
                begin
                    fin_valid       = 1'b1;
                    fin_data.status = STATUS_ABOVE;
                end
            end
            S_MUL:
            begin
                state_next = S_ADD;
            end
            S_ADD:
            begin
                state_next = S_SAT;
            end
            S_SAT:
            begin
                fin_valid             = 1'b1;
                fin_data.result_value = sat_value;
                fin_data.status       = STATUS_OK;
            end
            S_HOLD:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        if (fin_valid)
        begin
            state_next = out_free ? S_IDLE : S_HOLD;
        end
    end

    // output register loads from a fresh result or from the hold slot
    assign out_load      = out_free && (fin_valid || (state_reg == S_HOLD));
    assign out_load_data = (state_reg == S_HOLD) ? hold_reg : fin_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (res.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_data_reg <= out_load_data;
        end
    end

    assign res.valid   = out_valid_reg;
    assign res.payload = out_data_reg;

`ifndef ASSERT_OFF
    a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CHECK) |-> (cnt_reg < lim))
        else $error("segment scan past search limit");
    a_hold_means_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_HOLD) |-> out_valid_reg)
        else $error("result held while output register was free");
    a_pop_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> ((state_reg == S_IDLE) && !flags.empty))
        else $error("queue popped outside idle or while empty");
`endif
endmodule

[sim/plte_result_checker.sv]
// result checker for the piecewise-linear table evaluator: predicts and compares every transfer
`timescale 1ns / 100ps
module plte_result_checker
    import plte_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [DATA_W-1:0]      cfg_data,
    plte_cmd_if                    cmd,
    plte_res_if                    res,
    output int                     fail_count,
    output int                     outstanding
);

    seg_t                     seg_mem [MAX_SEGMENTS_DEF];
    logic signed [DATA_W-1:0] x_floor;
    logic [SIU_W-1:0]         search_len;
    res_t                     table_answers [$];

    // apply one accepted item to the table copy and work out its answer
    function automatic res_t table_lookup(input cmd_t c);
        res_t   r;
        seg_t   s;
        int     lim;
        bit     hit;
        longint acc;
        r.result_value = '0;
        r.status       = STATUS_ABOVE;
        hit            = 1'b0;
        if (c.command == CMD_WRITE)
        begin
            s.upper_x                = c.segment_upper_x;
            s.slope                  = c.segment_slope;
            s.intercept              = c.segment_intercept;
            seg_mem[c.segment_index] = s;
            r.status                 = STATUS_WRITTEN;
        end
        else if ($signed(c.x_value) < x_floor)
        begin
            r.status = STATUS_BELOW;
        end
        else
        begin
            // counts above the table size search the whole table
            lim = (search_len > MAX_SEGMENTS_DEF) ? MAX_SEGMENTS_DEF : int'(search_len);
            for (int i = 0; i < lim && !hit; i++)
            begin
                s = seg_mem[i];
                if ($signed(c.x_value) <= $signed(s.upper_x))
                begin
                    hit = 1'b1;
                    // exact Q32.32 sum, round half up, back to Q16.16
                    acc = longint'($signed(s.slope)) * longint'($signed(c.x_value))
                        + (longint'($signed(s.intercept)) <<< FRAC_W)
                        + (longint'(1) <<< (FRAC_W - 1));
                    acc = acc >>> FRAC_W;
                    if (acc > 64'sd2147483647)
                        acc = 64'sd2147483647;
                    if (acc < -64'sd2147483648)
                        acc = -64'sd2147483648;
                    r.result_value = acc[DATA_W-1:0];
                    r.status       = STATUS_OK;
                end
            end
        end
        return r;
    endfunction

    // watch config writes and both channels
    always @(posedge clk or negedge rst_n)
    begin : watch
        res_t want;
        res_t got;
        int   errs;
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_SEGMENTS_DEF; i++)
                seg_mem[i] = '0;
            x_floor    = '0;
            search_len = SIU_W'(1);
            table_answers.delete();
            fail_count  <= 0;
            outstanding <= 0;
        end
        else
        begin
            errs = 0;
            // result transfer against the oldest answer
            if (res.valid && res.ready)
            begin
                got = res.payload;
                if (table_answers.size() == 0)
                begin
                    $display("%0t unexpected result: expected none, actual value %h status %0d",
                             $time, got.result_value, got.status);
                    errs++;
                end
                else
                begin
                    want = table_answers.pop_front();
                    if (got.result_value !== want.result_value)
                    begin
                        $display("%0t result_value mismatch: expected %h actual %h",
                                 $time, want.result_value, got.result_value);
                        errs++;
                    end
                    if (got.status !== want.status)
                    begin
                        $display("%0t status mismatch: expected %0d actual %0d",
                                 $time, want.status, got.status);
                        errs++;
                    end
                end
            end
            // register writes
            if (cfg_we)
            begin
                case (cfg_reg_t'(cfg_index))
                    REG_MIN_X:           x_floor    = $signed(cfg_data);
                    REG_SEGMENTS_IN_USE: search_len = cfg_data[SIU_W-1:0];
                    default:             ;
                endcase
            end
            // input transfer
            if (cmd.valid && cmd.ready)
                table_answers.push_back(table_lookup(cmd.payload));
            fail_count  <= fail_count + errs;
            outstanding <= table_answers.size();
        end
    end

endmodule

[sim/tb_top.sv]
// testbench top for the piecewise-linear table evaluator: stimulus, output stalls and verdict
`timescale 1ns / 100ps
module tb_top;
    import plte_pkg::*;

    localparam int RANDOM_ITEMS   = 1750;
    localparam int PHASE_ITEMS    = 70;
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int TAIL_CYCLES    = 40;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [DATA_W-1:0]      cfg_data;
    int                     fail_count;
    int                     outstanding;

    plte_cmd_if cmd_ch ();
    plte_res_if res_ch ();

    piecewise_linear_table_eval_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd_ch),
        .res       (res_ch)
    );

    plte_result_checker scoreboard (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .cmd         (cmd_ch),
        .res         (res_ch),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    // stimulus-side view of the table and registers, used to aim x values
    logic signed [DATA_W-1:0] upper_copy [MAX_SEGMENTS_DEF];
    logic signed [DATA_W-1:0] cur_min;
    int                       cur_len;
    int                       n_eval = 0;
    int                       n_write = 0;
    int                       n_phase = 0;
    bit                       steady = 1'b0;
    bit                       stall_request = 1'b0;
    bit                       stall_served = 1'b0;
    int                       hold_left = 0;
    int                       idle_cycles = 0;

    // clock
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // receiver: random stalls, one long hold-off, a stretch with none
    always @(posedge clk)
    begin
        if (!rst_n)
            res_ch.ready <= 1'b0;
        else if (hold_left > 0)
        begin
            res_ch.ready <= 1'b0;
            hold_left    <= hold_left - 1;
        end
        else if (stall_request && !stall_served)
        begin
            res_ch.ready <= 1'b0;
            hold_left    <= HOLD_CYCLES - 1;
            stall_served <= 1'b1;
        end
        else if (steady)
            res_ch.ready <= 1'b1;
        else
            res_ch.ready <= ($urandom_range(99) >= 25);
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t watchdog: no transfer for %0d cycles", $time, idle_cycles);
                $display("status: fail");
                $finish;
            end
        end
    end

    function automatic logic [DATA_W-1:0] rand_coef(input bit wide);
        logic [DATA_W-1:0] r;
        r = $urandom;
        return wide ? r : {{12{r[19]}}, r[19:0]};
    endfunction

    function automatic cmd_t eval_item(input logic signed [DATA_W-1:0] x);
        cmd_t c;
        c.command           = CMD_EVALUATE;
        c.x_value           = x;
        c.segment_index     = IDX_W'($urandom);
        c.segment_upper_x   = $urandom;
        c.segment_slope     = $urandom;
        c.segment_intercept = $urandom;
        return c;
    endfunction

    // x near breakpoints, at or just below the range floor, or anywhere
    function automatic logic signed [DATA_W-1:0] pick_x();
        int sel;
        int lim;
        int k;
        sel = $urandom_range(99);
        lim = (cur_len > MAX_SEGMENTS_DEF) ? MAX_SEGMENTS_DEF : cur_len;
        k   = (lim == 0) ? $urandom_range(MAX_SEGMENTS_DEF - 1) : $urandom_range(lim - 1);
        if (sel < 35)
            return upper_copy[k];
        else if (sel < 55)
            return upper_copy[k] + 1;
        else if (sel < 65)
            return upper_copy[k] - $urandom_range(1000);
        else if (sel < 75)
            return cur_min;
        else if (sel < 80)
            return cur_min - 1;
        else
            return $urandom;
    endfunction

    // one input transfer, at times with a random gap ahead of it outside steady phases
    task automatic send(input cmd_t item);
        if (!steady && $urandom_range(99) < 25)
        begin
            cmd_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        cmd_ch.valid   <= 1'b1;
        cmd_ch.payload <= item;
        @(posedge clk);
        while (!cmd_ch.ready)
            @(posedge clk);
        if (item.command == CMD_WRITE)
            n_write++;
        else
            n_eval++;
    endtask

    task automatic load_segment(input int idx, input logic [DATA_W-1:0] up,
                                input logic [DATA_W-1:0] sl, input logic [DATA_W-1:0] ic);
        cmd_t c;
        c.command           = CMD_WRITE;
        c.x_value           = $urandom;
        c.segment_index     = IDX_W'(idx);
        c.segment_upper_x   = up;
        c.segment_slope     = sl;
        c.segment_intercept = ic;
        upper_copy[idx]     = up;
        send(c);
    endtask

    // stop offering and wait for every result
    task automatic drain();
        cmd_ch.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    // both registers, back to back, only while idle
    task automatic set_config(input logic [DATA_W-1:0] lo, input int len);
        cfg_we    <= 1'b1;
        cfg_index <= REG_MIN_X;
        cfg_data  <= lo;
        @(posedge clk);
        cfg_index <= REG_SEGMENTS_IN_USE;
        cfg_data  <= DATA_W'(len);
        @(posedge clk);
        cfg_we    <= 1'b0;
        cur_min   = lo;
        cur_len   = len;
        n_phase++;
    endtask

    initial
    begin : stimulus
        logic signed [DATA_W-1:0] base;
        logic signed [DATA_W-1:0] up;
        int                       style;
        int                       target;
        int                       phase;
        bit                       wide;

        rst_n          <= 1'b0;
        cfg_we         <= 1'b0;
        cfg_index      <= '0;
        cfg_data       <= '0;
        cmd_ch.valid   <= 1'b0;
        cmd_ch.payload <= '0;
        cur_min = '0;
        cur_len = 1;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: full table, saturating ends, half-LSB rounding segment
        for (int k = 0; k < MAX_SEGMENTS_DEF; k++)
        begin
            case (k)
                0:       load_segment(k, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
                1:       load_segment(k, 32'hFC18_0000, 32'h8000_0000, 32'h7FFF_FFFF);
                8:       load_segment(k, DATA_W'((k * 64 - 500) * 65536), 32'h0000_8000, '0);
                15:      load_segment(k, 32'h7FFF_FFFF, 32'h0001_0000, '0);
                default: load_segment(k, DATA_W'((k * 64 - 500) * 65536),
                                      rand_coef(1'b0), rand_coef(1'b0));
            endcase
        end
        // reset settings: below range, then above range past segment zero
        send(eval_item(-32'sd1));
        send(eval_item(32'sd0));
        drain();
        set_config(32'h8000_0000, 16);
        send(eval_item(32'sh8000_0000));
        send(eval_item(32'shF830_0000));
        send(eval_item(32'sh7FFF_FFFF));
        send(eval_item(32'sd1));
        send(eval_item(-32'sd1));
        // no segments searched
        drain();
        set_config(32'h8000_0000, 0);
        send(eval_item(32'sd5));
        // floor at the top, count beyond the table
        drain();
        set_config(32'h7FFF_FFFF, 31);
        send(eval_item(32'sh7FFF_FFFE));
        send(eval_item(32'sh7FFF_FFFF));

        // random phases: settings, fresh table, then mostly aimed evaluates
        target = n_eval + n_write + RANDOM_ITEMS;
        phase  = 0;
        while (n_eval + n_write < target)
        begin
            drain();
            style = phase % 3;
            base  = $signed($urandom_range(0, 32'h3FFF_FFFF)) - 32'sh4000_0000;
            case (phase % 8)
                0:       set_config(32'h8000_0000, 16);
                1:       set_config($urandom, $urandom_range(1, 16));
                2:       set_config(base - $urandom_range(0, 1 << 20), 16);
                3:       set_config('0, 0);
                4:       set_config(32'h7FFF_FFFF, 31);
                5:       set_config(32'h8000_0000, $urandom_range(17, 31));
                6:       set_config(-$urandom_range(0, 1 << 24), 1);
                default: set_config($urandom, $urandom_range(0, 31));
            endcase
            steady <= (phase == 3 || phase == 4);
            if (phase == 6)
                stall_request <= 1'b1;
            up = base;
            for (int k = 0; k < MAX_SEGMENTS_DEF; k++)
            begin
                wide = (style == 1) || (style == 2 && $urandom_range(1) == 1);
                if (style == 2)
                    up = $urandom;
                else
                    up = up + $urandom_range(1, 1 << 26);
                load_segment(k, up, rand_coef(wide), rand_coef(wide));
            end
            repeat (PHASE_ITEMS)
            begin
                wide = ($urandom_range(1) == 1);
                if ($urandom_range(99) < 15)
                    load_segment($urandom_range(MAX_SEGMENTS_DEF - 1), $urandom,
                                 rand_coef(wide), rand_coef(wide));
                else
                    send(eval_item(pick_x()));
            end
            phase++;
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        $display("covered %0d evaluates and %0d segment writes over %0d register settings",
                 n_eval, n_write, n_phase);
        $display("settings spanned both range floor extremes, zero and oversized segment counts");
        if (fail_count == 0 && outstanding == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

[sim.f]
rtl/core/plte_pkg.sv
rtl/core/plte_cmd_if.sv
rtl/core/plte_res_if.sv
rtl/core/plte_ram.sv
rtl/core/plte_queue.sv
rtl/core/plte_front.sv
rtl/core/plte_back.sv
rtl/core/piecewise_linear_table_eval_core.sv
sim/plte_result_checker.sv
sim/tb_top.sv
